>>> rtl/core/stbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_pkg
// shared types and constants for the sorted lookup table
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int VALUE_W         = 32;
    localparam int POS_W           = 4;

    // request type codes
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT_START,
        ST_SORT_SCAN,
        ST_SORT_WR_LO,
        ST_SORT_WR_HI,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_RESULT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic srch_start;
        logic sort_start;
        logic scan_step;
        logic swap_lo;
        logic swap_hi;
        logic srch_issue;
        logic srch_miss;
        logic srch_cmp;
        logic res_write;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic sort_trivial;
        logic scan_done;
        logic sort_last;
        logic range_empty;
        logic key_eq;
    } dp_stat_t;

endpackage

>>> rtl/core/stbs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_datapath
// value memory, entry count, selection sort scan and binary search registers
// ----------------------------------------------------------------------------
module stbs_datapath #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  stbs_pkg::dp_cmd_t                      cmd,
    output stbs_pkg::dp_stat_t                     stat,
    input  logic                                   set_last,
    input  logic signed [stbs_pkg::VALUE_W-1:0]    load_value,
    input  logic signed [stbs_pkg::VALUE_W-1:0]    search_key,
    output logic                                   found,
    output logic        [stbs_pkg::POS_W-1:0]      position
);
    import stbs_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    logic signed [VALUE_W-1:0] mem [TABLE_DEPTH];

    logic [CW-1:0] count_reg, count_next;
    logic          open_reg, open_next;
    logic          pend_reg, pend_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] m_reg, m_next;
    logic [CW-1:0] pend_idx_reg, pend_idx_next;
    logic          first_reg, first_next;
    logic          pend_first_reg, pend_first_next;
    logic signed [VALUE_W-1:0] min_reg, min_next;
    logic signed [VALUE_W-1:0] vi_reg, vi_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;     // exclusive upper end
    logic [CW-1:0] mid_reg, mid_next;
    logic signed [VALUE_W-1:0] key_reg, key_next;
    logic          hit_reg, hit_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic          found_reg, found_next;
    logic [POS_W-1:0] position_reg, position_next;
    logic signed [VALUE_W-1:0] rd_data_reg;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic signed [VALUE_W-1:0] wr_data;
    logic          rd_en;
    logic [IW-1:0] rd_addr;

    logic [CW-1:0]       count_base;
    logic [CW:0]         mid_sum;
    logic [CW-1:0]       mid;
    logic [CW+POS_W-1:0] mid_ext;
    logic                scan_issue;

    // floored midpoint of the inclusive range lo..hi-1
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - {{CW{1'b0}}, 1'b1};
    assign mid     = mid_sum[CW:1];
    assign mid_ext = {{POS_W{1'b0}}, mid_reg};

    assign count_base = open_reg ? count_reg : '0;
    assign scan_issue = cmd.scan_step && (j_reg < count_reg);

    assign rd_en   = scan_issue || cmd.srch_issue;
    assign rd_addr = cmd.scan_step ? j_reg[IW-1:0] : mid[IW-1:0];

    assign stat.sort_trivial = count_reg < TWO_C;
    assign stat.scan_done    = (j_reg >= count_reg) && !pend_reg;
    assign stat.sort_last    = (i_reg + ONE_C) >= count_reg;
    assign stat.range_empty  = lo_reg >= hi_reg;
    assign stat.key_eq       = rd_data_reg == key_reg;

    always_comb
    begin
        count_next      = count_reg;
        open_next       = open_reg;
        pend_next       = 1'b0;
        i_next          = i_reg;
        j_next          = j_reg;
        m_next          = m_reg;
        pend_idx_next   = pend_idx_reg;
        first_next      = first_reg;
        pend_first_next = pend_first_reg;
        min_next        = min_reg;
        vi_next         = vi_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        key_next        = key_reg;
        hit_next        = hit_reg;
        pos_next        = pos_reg;
        found_next      = found_reg;
        position_next   = position_reg;
        wr_en           = 1'b0;
        wr_addr         = i_reg[IW-1:0];
        wr_data         = min_reg;

        if (cmd.load)
        begin
            open_next = !set_last;
            if (count_base < DEPTH_C)
            begin
                wr_en      = 1'b1;
                wr_addr    = count_base[IW-1:0];
                wr_data    = load_value;
                count_next = count_base + ONE_C;
            end
            else
            begin
                count_next = count_base;
            end
        end

        if (cmd.sort_start)
        begin
            i_next     = '0;
            j_next     = '0;
            first_next = 1'b1;
        end

        if (cmd.scan_step)
        begin
            pend_next       = scan_issue;
            pend_first_next = first_reg;
            pend_idx_next   = j_reg;
            if (scan_issue)
            begin
                j_next     = j_reg + ONE_C;
                first_next = 1'b0;
            end
            if (pend_reg)
            begin
                if (pend_first_reg || (rd_data_reg < min_reg))
                begin
                    min_next = rd_data_reg;
                    m_next   = pend_idx_reg;
                end
                if (pend_first_reg)
                begin
                    vi_next = rd_data_reg;
                end
            end
        end

        if (cmd.swap_lo)
        begin
            wr_en   = 1'b1;
            wr_addr = i_reg[IW-1:0];
            wr_data = min_reg;
        end

        if (cmd.swap_hi)
        begin
            wr_en      = 1'b1;
            wr_addr    = m_reg[IW-1:0];
            wr_data    = vi_reg;
            i_next     = i_reg + ONE_C;
            j_next     = i_reg + ONE_C;
            first_next = 1'b1;
        end

        if (cmd.srch_start)
        begin
            key_next = search_key;
            lo_next  = '0;
            hi_next  = count_reg;
        end

        if (cmd.srch_issue)
        begin
            mid_next = mid;
        end

        if (cmd.srch_miss)
        begin
            hit_next = 1'b0;
            pos_next = '0;
        end

        if (cmd.srch_cmp)
        begin
            if (rd_data_reg == key_reg)
            begin
                hit_next = 1'b1;
                pos_next = mid_ext[POS_W-1:0];
            end
            else if (key_reg < rd_data_reg)
            begin
                hi_next = mid_reg;
            end
            else
            begin
                lo_next = mid_reg + ONE_C;
            end
        end

        if (cmd.res_write)
        begin
            found_next    = hit_reg;
            position_next = pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            open_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            open_reg  <= open_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        j_reg          <= j_next;
        m_reg          <= m_next;
        pend_idx_reg   <= pend_idx_next;
        first_reg      <= first_next;
        pend_first_reg <= pend_first_next;
        min_reg        <= min_next;
        vi_reg         <= vi_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        key_reg        <= key_next;
        hit_reg        <= hit_next;
        pos_reg        <= pos_next;
        found_reg      <= found_next;
        position_reg   <= position_next;
    end

    // value memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign found    = found_reg;
    assign position = position_reg;

    count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count beyond table depth");

    swap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.swap_lo |-> (m_reg < count_reg) && (i_reg < count_reg) && (m_reg >= i_reg))
        else $error("swap indices outside the unsorted range");

    probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.srch_cmp |-> (mid_reg < count_reg))
        else $error("search probe beyond the stored entries");

endmodule

>>> rtl/core/stbs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_ctrl
// request sequencing for load, sort and search, plus result handshake
// ----------------------------------------------------------------------------
module stbs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  logic               set_last,
    output logic               out_valid,
    input  logic               out_stall,
    output stbs_pkg::dp_cmd_t  cmd,
    input  stbs_pkg::dp_stat_t stat
);
    import stbs_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (req_type == REQ_LOAD)
                    begin
                        cmd.load = 1'b1;
                        if (set_last)
                        begin
                            state_next = ST_SORT_START;
                        end
                    end
                    else
                    begin
                        cmd.srch_start = 1'b1;
                        state_next     = ST_SRCH_RD;
                    end
                end
            end
            ST_SORT_START:
            begin
                if (stat.sort_trivial)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.sort_start = 1'b1;
                    state_next     = ST_SORT_SCAN;
                end
            end
            ST_SORT_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_SORT_WR_LO;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_SORT_WR_LO:
            begin
                cmd.swap_lo = 1'b1;
                state_next  = ST_SORT_WR_HI;
            end
            ST_SORT_WR_HI:
            begin
                cmd.swap_hi = 1'b1;
                // the last position is already in place
                state_next  = stat.sort_last ? ST_IDLE : ST_SORT_SCAN;
                if (stat.sort_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SRCH_RD:
            begin
                if (stat.range_empty)
                begin
                    cmd.srch_miss = 1'b1;
                    state_next    = ST_RESULT;
                end
                else
                begin
                    cmd.srch_issue = 1'b1;
                    state_next     = ST_SRCH_CMP;
                end
            end
            ST_SRCH_CMP:
            begin
                cmd.srch_cmp = 1'b1;
                state_next   = stat.key_eq ? ST_RESULT : ST_SRCH_RD;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    cmd.res_write = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = cmd.res_write || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    result_from_search: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("result raised outside the result state");

    sort_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && set_last) |=> (state_reg == ST_SORT_START) && in_stall)
        else $error("closing load did not start the sort");

endmodule

>>> rtl/core/sort_then_binary_search_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sort_then_binary_search_table_top: sorted lookup table with binary search
// load: accepted only while idle; a closing load then holds the input through
//   a selection sort on n >= 2 entries (just the sort-start check otherwise)
// search: each probe is a registered memory read, then a compare; at most
//   ceil(log2(n+1)) probes; one request in work at a time
// reset: asynchronous, empties the table and closes any open set
// ----------------------------------------------------------------------------
module sort_then_binary_search_table_top #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                req_type,
    input  logic signed [stbs_pkg::VALUE_W-1:0] load_value,
    input  logic                                set_last,
    input  logic signed [stbs_pkg::VALUE_W-1:0] search_key,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                found,
    output logic        [stbs_pkg::POS_W-1:0]   position
);
    import stbs_pkg::*;

    // command and status between the sequencer and the datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: takes a request only when idle, walks the sort passes and
    // search probes, and parks a finished search until the result register
    // is free; new requests stall while a finished search is parked
    stbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .set_last  (set_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // datapath: value memory with entry count and open-set flag, min-finding
    // scan for the selection sort, lo/hi range for the search, result register
    stbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .set_last   (set_last),
        .load_value (load_value),
        .search_key (search_key),
        .found      (found),
        .position   (position)
    );

endmodule
